// File: sv/mec_pkg.sv
// Shared types and constants for the motor end-stop calibrator.
// Request and response payloads, op, phase and command codes, register map.
// No dependencies.
package mec_pkg;

  localparam int PortCountDefault = 4;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    REG_SETTLE_TICKS  = 2'd0,
    REG_LIMIT_MARGIN  = 2'd1,
    REG_SWEEP_SPEED   = 2'd2,
    REG_SWEEP_TIME_MS = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  SettleTicksReset = 8'd5;
  localparam logic [9:0]  LimitMarginReset = 10'd20;
  localparam logic [6:0]  SweepSpeedReset  = 7'd70;
  localparam logic [15:0] SweepTimeReset   = 16'd300;
  localparam logic [6:0]  SpeedMax         = 7'd100;
  localparam logic signed [7:0] PosCmdSpeed = 8'sd100;

  localparam logic [2:0] OP_REPORT = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_RESET  = 3'd3;
  localparam logic [2:0] OP_STEER  = 3'd4;

  localparam logic [2:0] PH_INIT  = 3'd0;
  localparam logic [2:0] PH_READY = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_NEG   = 3'd3;
  localparam logic [2:0] PH_POS   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_NONE  = 3'd6;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_TIMED = 2'd1;
  localparam logic [1:0] CMD_ABS   = 2'd2;

  localparam logic signed [7:0] DIR_LEFT   = -8'sd1;
  localparam logic signed [7:0] DIR_CENTER = 8'sd0;
  localparam logic signed [7:0] DIR_RIGHT  = 8'sd1;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         port;
    logic               is_tacho;
    logic signed [31:0] position;
    logic signed [7:0]  direction;
  } req_t;

  typedef struct packed {
    logic [1:0]         cmd_kind;
    logic [1:0]         cmd_port;
    logic signed [7:0]  cmd_speed;
    logic [15:0]        cmd_time_ms;
    logic signed [31:0] cmd_angle;
    logic               ok;
    logic [2:0]         port_state;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [9:0]  limit_margin;
    logic [6:0]  sweep_speed;
    logic [15:0] sweep_time_ms;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic read_en;
    logic calc_en;
  } dp_cmd_t;

endpackage

// File: sv/mec_regs.sv
// APB configuration registers of the motor end-stop calibrator.
// Depends on mec_pkg for the register map and cfg_t.
module mec_regs import mec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks  <= SettleTicksReset;
      cfg_q.limit_margin  <= LimitMarginReset;
      cfg_q.sweep_speed   <= SweepSpeedReset;
      cfg_q.sweep_time_ms <= SweepTimeReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= pwdata[7:0];
        REG_LIMIT_MARGIN:  cfg_q.limit_margin  <= pwdata[9:0];
        REG_SWEEP_SPEED:   cfg_q.sweep_speed   <= pwdata[6:0];
        REG_SWEEP_TIME_MS: cfg_q.sweep_time_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETTLE_TICKS:  prdata = {24'd0, cfg_q.settle_ticks};
      REG_LIMIT_MARGIN:  prdata = {22'd0, cfg_q.limit_margin};
      REG_SWEEP_SPEED:   prdata = {25'd0, cfg_q.sweep_speed};
      REG_SWEEP_TIME_MS: prdata = {16'd0, cfg_q.sweep_time_ms};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: sv/mec_ctrl.sv
// Sequencing controller of the motor end-stop calibrator.
// Steps each request through capture, state read and compute; owns both handshakes.
// Depends on mec_pkg for dp_cmd_t.
module mec_ctrl import mec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = S_CALC;
      end
      S_CALC: begin
        if (out_free) begin
          cmd_o.calc_en = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/mec_dp.sv
// Datapath of the motor end-stop calibrator: per-port state table,
// limit arithmetic and the response register. Depends on mec_pkg.
module mec_dp import mec_pkg::*; #(
  parameter int PORT_COUNT = PortCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  cfg_t    cfg_i,
  input  req_t    in_req_i,
  output rsp_t    out_rsp_o
);

  localparam int IdxW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  req_t req_q;
  rsp_t rsp_q, rsp_d;

  logic [2:0]         phase_q [PORT_COUNT];
  logic signed [31:0] last_q  [PORT_COUNT];
  logic signed [31:0] left_q  [PORT_COUNT];
  logic signed [31:0] right_q [PORT_COUNT];
  logic [7:0]         wait_q  [PORT_COUNT];

  logic [IdxW+1:0] port_ext;
  logic [IdxW-1:0] idx;
  logic            port_ok;

  logic [2:0]         rd_phase_q;
  logic signed [31:0] rd_last_q, rd_left_q, rd_right_q;
  logic [7:0]         rd_wait_q;
  logic [32:0]        sum_q;
  logic [31:0]        plus_q, minus_q;
  logic               lt_left_q, gt_right_q, wait_lt_q;

  logic [32:0] sum_d, plus_w, minus_w;

  logic [2:0]         n_phase;
  logic signed [31:0] n_last, n_left, n_right;
  logic [7:0]         n_wait;
  logic [6:0]         speed_sat;
  logic signed [7:0]  speed_pos, speed_neg;
  logic [32:0]        mean_w;
  logic signed [31:0] mean;

  assign port_ext = {{IdxW{1'b0}}, req_q.port};
  assign idx      = port_ext[IdxW-1:0];
  assign port_ok  = ({30'd0, req_q.port} < 32'(PORT_COUNT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= in_req_i;
    end
  end

  // read stage: fetch the port entry and precompute limit arithmetic
  assign sum_d   = {left_q[idx][31], left_q[idx]} + {right_q[idx][31], right_q[idx]};
  assign plus_w  = {last_q[idx][31], last_q[idx]} + {23'd0, cfg_i.limit_margin};
  assign minus_w = {last_q[idx][31], last_q[idx]} - {23'd0, cfg_i.limit_margin};

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      rd_phase_q <= phase_q[idx];
      rd_last_q  <= last_q[idx];
      rd_left_q  <= left_q[idx];
      rd_right_q <= right_q[idx];
      rd_wait_q  <= wait_q[idx];
      sum_q      <= sum_d;
      plus_q     <= (plus_w[32] != plus_w[31]) ?
                    (plus_w[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : plus_w[31:0];
      minus_q    <= (minus_w[32] != minus_w[31]) ?
                    (minus_w[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : minus_w[31:0];
      lt_left_q  <= last_q[idx] < left_q[idx];
      gt_right_q <= last_q[idx] > right_q[idx];
      wait_lt_q  <= wait_q[idx] < cfg_i.settle_ticks;
    end
  end

  // compute stage
  assign speed_sat = (cfg_i.sweep_speed > SpeedMax) ? SpeedMax : cfg_i.sweep_speed;
  assign speed_pos = {1'b0, speed_sat};
  assign speed_neg = 8'sd0 - speed_pos;
  assign mean_w    = sum_q + {32'd0, sum_q[32]};
  assign mean      = mean_w[32:1];

  always_comb begin
    n_phase = rd_phase_q;
    n_last  = rd_last_q;
    n_left  = rd_left_q;
    n_right = rd_right_q;
    n_wait  = rd_wait_q;
    rsp_d   = '0;
    rsp_d.cmd_port = req_q.port;
    case (req_q.op)
      OP_REPORT: begin
        if (req_q.is_tacho) begin
          n_last = req_q.position;
          if (rd_phase_q == PH_INIT) begin
            n_phase = PH_READY;
          end
        end else begin
          n_phase = PH_NONE;
        end
      end
      OP_TICK: begin
        if (rd_phase_q == PH_NONE || rd_phase_q == PH_DONE) begin
          rsp_d.ok = 1'b1;
        end else if (wait_lt_q) begin
          n_wait = rd_wait_q + 8'd1;
        end else begin
          n_wait = 8'd0;
          case (rd_phase_q)
            PH_START: begin
              n_phase           = PH_NEG;
              n_left            = plus_q;
              rsp_d.cmd_kind    = CMD_TIMED;
              rsp_d.cmd_speed   = speed_neg;
              rsp_d.cmd_time_ms = cfg_i.sweep_time_ms;
            end
            PH_NEG: begin
              rsp_d.cmd_kind    = CMD_TIMED;
              rsp_d.cmd_time_ms = cfg_i.sweep_time_ms;
              if (lt_left_q) begin
                rsp_d.cmd_speed = speed_neg;
                n_left          = rd_last_q;
              end else begin
                rsp_d.cmd_speed = speed_pos;
                n_right         = minus_q;
                n_phase         = PH_POS;
              end
            end
            PH_POS: begin
              if (gt_right_q) begin
                rsp_d.cmd_kind    = CMD_TIMED;
                rsp_d.cmd_speed   = speed_pos;
                rsp_d.cmd_time_ms = cfg_i.sweep_time_ms;
                n_right           = rd_last_q;
              end else begin
                n_phase         = PH_DONE;
                rsp_d.ok        = 1'b1;
                rsp_d.cmd_kind  = CMD_ABS;
                rsp_d.cmd_speed = PosCmdSpeed;
              end
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        if (rd_phase_q == PH_READY) begin
          n_phase  = PH_START;
          rsp_d.ok = 1'b1;
        end
      end
      OP_RESET: begin
        n_phase = PH_INIT;
        n_last  = '0;
        n_left  = '0;
        n_right = '0;
        n_wait  = '0;
      end
      OP_STEER: begin
        rsp_d.cmd_kind  = CMD_ABS;
        rsp_d.cmd_speed = PosCmdSpeed;
        if (req_q.direction == DIR_LEFT) begin
          rsp_d.cmd_angle = rd_left_q;
        end else if (req_q.direction == DIR_RIGHT) begin
          rsp_d.cmd_angle = rd_right_q;
        end else if (req_q.direction == DIR_CENTER) begin
          rsp_d.cmd_angle = mean;
        end
      end
      default: ;
    endcase
    rsp_d.port_state = n_phase;
    if (!port_ok) begin
      rsp_d          = '0;
      rsp_d.cmd_port = req_q.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        phase_q[i] <= PH_INIT;
        last_q[i]  <= '0;
        left_q[i]  <= '0;
        right_q[i] <= '0;
        wait_q[i]  <= '0;
      end
    end else if (cmd_i.calc_en && port_ok) begin
      phase_q[idx] <= n_phase;
      last_q[idx]  <= n_last;
      left_q[idx]  <= n_left;
      right_q[idx] <= n_right;
      wait_q[idx]  <= n_wait;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

// File: sv/motor_endstop_calibrator_unit.sv
// Motor end-stop calibrator: one response per request, for up to PORT_COUNT motor ports.
// Each request passes capture, read of the port's state entry with the limit sums, then
// compute and write back; the single port state table is read-modify-written, so a new
// request waits for write back. The response sits in an output register, so the next
// request is taken while it waits. Reset clears all port state at once. Configuration
// goes through the APB port; writing it only while the block is idle is up to the user.
module motor_endstop_calibrator_unit import mec_pkg::*; #(
  parameter int PORT_COUNT = PortCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  dp_cmd_t dp_cmd;

  mec_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  mec_dp #(
    .PORT_COUNT (PORT_COUNT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .cfg_i     (cfg),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// File: tb/sv/motor_endstop_calibrator_checker.sv
`timescale 1ns / 100ps
// Checker for the motor end-stop calibrator: predicts one response per accepted request
// and compares it with the block's responses in order. Tracks APB register writes.
// Depends on mec_pkg.
module motor_endstop_calibrator_checker import mec_pkg::*; #(
  parameter int PORT_COUNT = PortCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  req_t                in_req_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rsp_t                out_rsp_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [CfgDataW-1:0] pwdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int PosMax = 32'h7fffffff;
  localparam int PosMin = 32'h80000000;

  logic [2:0] phase_q    [PORT_COUNT];
  int         last_pos_q [PORT_COUNT];
  int         left_q     [PORT_COUNT];
  int         right_q    [PORT_COUNT];
  logic [7:0] wait_q     [PORT_COUNT];
  cfg_t       cfg_q;
  rsp_t       due_cmds [$];
  rsp_t       want;
  int         fails = 0;

  assign fail_count_o = fails;

  function automatic void clear_port(int p);
    phase_q[p]    = PH_INIT;
    last_pos_q[p] = 0;
    left_q[p]     = 0;
    right_q[p]    = 0;
    wait_q[p]     = '0;
  endfunction

  function automatic int clamp32(longint v);
    if (v > longint'(PosMax)) return PosMax;
    if (v < longint'(PosMin)) return PosMin;
    return int'(v);
  endfunction

  function automatic rsp_t sweep_cmd(rsp_t c, bit negative);
    logic signed [7:0] spd;
    spd = {1'b0, (cfg_q.sweep_speed > SpeedMax) ? SpeedMax : cfg_q.sweep_speed};
    c.cmd_kind    = CMD_TIMED;
    c.cmd_speed   = negative ? -spd : spd;
    c.cmd_time_ms = cfg_q.sweep_time_ms;
    c.cmd_angle   = '0;
    return c;
  endfunction

  function automatic rsp_t angle_cmd(rsp_t c, int angle);
    c.cmd_kind    = CMD_ABS;
    c.cmd_speed   = PosCmdSpeed;
    c.cmd_time_ms = '0;
    c.cmd_angle   = angle;
    return c;
  endfunction

  function automatic rsp_t predict_command(req_t r);
    rsp_t   c;
    int     p;
    int     cur;
    longint m;
    c = '0;
    c.cmd_port = r.port;
    if (int'(r.port) >= PORT_COUNT) return c;
    p   = int'(r.port);
    cur = last_pos_q[p];
    m   = longint'(cfg_q.limit_margin);
    case (r.op)
      OP_REPORT: begin
        if (r.is_tacho) begin
          last_pos_q[p] = r.position;
          if (phase_q[p] == PH_INIT) phase_q[p] = PH_READY;
        end else begin
          phase_q[p] = PH_NONE;
        end
      end
      OP_TICK: begin
        if (phase_q[p] == PH_NONE || phase_q[p] == PH_DONE) begin
          c.ok = 1'b1;
        end else if (wait_q[p] < cfg_q.settle_ticks) begin
          wait_q[p]++;
        end else begin
          wait_q[p] = '0;
          case (phase_q[p])
            PH_START: begin
              phase_q[p] = PH_NEG;
              left_q[p]  = clamp32(longint'(cur) + m);
              c = sweep_cmd(c, 1'b1);
            end
            PH_NEG: begin
              if (cur < left_q[p]) begin
                c = sweep_cmd(c, 1'b1);
                left_q[p] = cur;
              end else begin
                right_q[p] = clamp32(longint'(cur) - m);
                c = sweep_cmd(c, 1'b0);
                phase_q[p] = PH_POS;
              end
            end
            PH_POS: begin
              if (cur > right_q[p]) begin
                c = sweep_cmd(c, 1'b0);
                right_q[p] = cur;
              end else begin
                phase_q[p] = PH_DONE;
                c.ok = 1'b1;
                c = angle_cmd(c, 0);
              end
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        if (phase_q[p] == PH_READY) begin
          phase_q[p] = PH_START;
          c.ok = 1'b1;
        end
      end
      OP_RESET: clear_port(p);
      OP_STEER: begin
        if (r.direction == DIR_LEFT) begin
          c = angle_cmd(c, left_q[p]);
        end else if (r.direction == DIR_RIGHT) begin
          c = angle_cmd(c, right_q[p]);
        end else if (r.direction == DIR_CENTER) begin
          c = angle_cmd(c, int'((longint'(left_q[p]) + longint'(right_q[p])) / 2));
        end else begin
          c = angle_cmd(c, 0);
        end
      end
      default: ;
    endcase
    c.port_state = phase_q[p];
    return c;
  endfunction

  function automatic string show(rsp_t c);
    return $sformatf("kind=%0d port=%0d speed=%0d time=%0d angle=%0d ok=%0d state=%0d",
                     c.cmd_kind, c.cmd_port, c.cmd_speed, c.cmd_time_ms, c.cmd_angle,
                     c.ok, c.port_state);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORT_COUNT; p++) clear_port(p);
      cfg_q.settle_ticks  = SettleTicksReset;
      cfg_q.limit_margin  = LimitMarginReset;
      cfg_q.sweep_speed   = SweepSpeedReset;
      cfg_q.sweep_time_ms = SweepTimeReset;
      due_cmds.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[CfgAddrW-1:2]))
          REG_SETTLE_TICKS:  cfg_q.settle_ticks  = pwdata_i[7:0];
          REG_LIMIT_MARGIN:  cfg_q.limit_margin  = pwdata_i[9:0];
          REG_SWEEP_SPEED:   cfg_q.sweep_speed   = pwdata_i[6:0];
          REG_SWEEP_TIME_MS: cfg_q.sweep_time_ms = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (due_cmds.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected response: %s", show(out_rsp_i));
        end else begin
          want = due_cmds.pop_front();
          if (out_rsp_i.cmd_kind !== want.cmd_kind || out_rsp_i.cmd_port !== want.cmd_port ||
              out_rsp_i.cmd_speed !== want.cmd_speed ||
              out_rsp_i.cmd_time_ms !== want.cmd_time_ms ||
              out_rsp_i.cmd_angle !== want.cmd_angle || out_rsp_i.ok !== want.ok ||
              out_rsp_i.port_state !== want.port_state) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch at %0t: expected %s", $realtime, show(want));
              $display("                   actual %s", show(out_rsp_i));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) due_cmds.push_back(predict_command(in_req_i));
      pending_o <= due_cmds.size();
    end
  end

endmodule

// File: tb/sv/motor_endstop_calibrator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for motor_endstop_calibrator_unit: drives requests, APB writes and
// response back-pressure, and gives the verdict. Depends on mec_pkg and the checker.
module motor_endstop_calibrator_unit_tb;
  import mec_pkg::*;

  localparam int HoldLimit = 4000;
  localparam int PosMax    = 32'h7fffffff;
  localparam int PosMin    = 32'h80000000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  req_t                in_req    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rsp_t                out_rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [CfgDataW-1:0] pwdata    = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int                  fail_count;
  int                  pending;
  int                  send_idle   = 26;
  int                  recv_idle   = 77;
  int                  item_count  = 0;
  int                  idle_cycles = 0;
  logic [7:0]          settle_now  = SettleTicksReset;
  logic signed [7:0]   odd_dirs [5];

  always #4 clk = ~clk;

  motor_endstop_calibrator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  motor_endstop_calibrator_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HoldLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [2:0] op, logic [1:0] port, logic tacho, int pos,
                                    logic signed [7:0] dir);
    req_t r;
    r.op        = op;
    r.port      = port;
    r.is_tacho  = tacho;
    r.position  = pos;
    r.direction = dir;
    return r;
  endfunction

  function automatic req_t noise_req();
    return make_req(3'($urandom_range(7)), 2'($urandom), 1'($urandom), $urandom,
                    8'($urandom));
  endfunction

  function automatic int pick_position();
    case ($urandom_range(3))
      0: return $urandom;
      1: return PosMax - int'($urandom_range(1500));
      2: return PosMin + int'($urandom_range(1500));
      default: return int'($urandom_range(4000)) - 2000;
    endcase
  endfunction

  task automatic push_request(req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_SETTLE_TICKS) settle_now = value[7:0];
  endtask

  task automatic feed(req_t r);
    if ($urandom_range(99) < 12) push_request(noise_req());
    push_request(r);
  endtask

  task automatic tick_round(logic [1:0] port);
    repeat (int'(settle_now) + 1)
      feed(make_req(OP_TICK, port, 1'($urandom), $urandom, 8'($urandom)));
  endtask

  task automatic run_sweep(logic [1:0] port);
    int     pos;
    longint nx;
    pos = pick_position();
    feed(make_req(OP_RESET, port, 1'($urandom), $urandom, 8'($urandom)));
    feed(make_req(OP_REPORT, port, 1'b1, pos, 8'($urandom)));
    feed(make_req(OP_START, port, 1'($urandom), $urandom, 8'($urandom)));
    tick_round(port);
    repeat ($urandom_range(3)) begin
      nx = longint'(pos) - longint'($urandom_range(1, 2000));
      if (nx >= longint'(PosMin)) pos = int'(nx);
      feed(make_req(OP_REPORT, port, 1'b1, pos, 8'($urandom)));
      tick_round(port);
    end
    tick_round(port);
    tick_round(port);
    repeat ($urandom_range(3)) begin
      nx = longint'(pos) + longint'($urandom_range(1, 2000));
      if (nx <= longint'(PosMax)) pos = int'(nx);
      feed(make_req(OP_REPORT, port, 1'b1, pos, 8'($urandom)));
      tick_round(port);
    end
    tick_round(port);
    tick_round(port);
    feed(make_req(OP_STEER, port, 1'($urandom), $urandom, DIR_LEFT));
    feed(make_req(OP_STEER, port, 1'($urandom), $urandom, DIR_CENTER));
    feed(make_req(OP_STEER, port, 1'($urandom), $urandom,
                  $urandom_range(3) == 0 ? 8'($urandom) : DIR_RIGHT));
  endtask

  task automatic run_phase(int target);
    while (item_count < target) begin
      if ($urandom_range(3) != 0) begin
        run_sweep(2'($urandom));
      end else begin
        repeat (6) push_request(noise_req());
      end
    end
  endtask

  initial begin
    odd_dirs = '{-8'sd128, 8'sd127, DIR_LEFT, DIR_RIGHT, 8'sd2};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(make_req(OP_RESET, 2'd0, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_STEER, 2'd0, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_REPORT, 2'd3, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_TICK, 2'd3, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_START, 2'd3, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_REPORT, 2'd3, 1'b1, PosMax, DIR_CENTER));
    push_request(make_req(OP_REPORT, 2'd1, 1'b1, PosMin, DIR_CENTER));
    push_request(make_req(OP_START, 2'd1, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_START, 2'd1, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_TICK, 2'd0, 1'b0, 0, DIR_CENTER));
    for (int op = int'(OP_STEER) + 1; op < 8; op++)
      push_request(make_req(3'(op), 2'd2, 1'b1, -1, -8'sd128));
    foreach (odd_dirs[i]) push_request(make_req(OP_STEER, 2'd1, 1'b0, 0, odd_dirs[i]));
    repeat (6) push_request(make_req(OP_TICK, 2'd1, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_STEER, 2'd1, 1'b0, 0, DIR_LEFT));
    push_request(make_req(OP_STEER, 2'd1, 1'b0, 0, DIR_CENTER));
    drain();

    write_reg(REG_SETTLE_TICKS, 32'd0);
    write_reg(REG_LIMIT_MARGIN, 32'd1023);
    write_reg(REG_SWEEP_SPEED, 32'd127);
    write_reg(REG_SWEEP_TIME_MS, 32'd65535);
    run_phase(item_count + 60);
    drain();

    send_idle = 77;
    recv_idle = 26;
    write_reg(REG_SETTLE_TICKS, 32'd2);
    write_reg(REG_LIMIT_MARGIN, 32'd0);
    write_reg(REG_SWEEP_SPEED, 32'd0);
    write_reg(REG_SWEEP_TIME_MS, 32'd0);
    run_phase(item_count + 60);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_SETTLE_TICKS, 32'd1);
    write_reg(REG_LIMIT_MARGIN, 32'($urandom_range(1, 1022)));
    write_reg(REG_SWEEP_SPEED, 32'd100);
    write_reg(REG_SWEEP_TIME_MS, 32'($urandom_range(65535)));
    run_phase(item_count + 60);
    drain();

    write_reg(REG_SETTLE_TICKS, 32'd255);
    push_request(make_req(OP_RESET, 2'd2, 1'b0, 0, DIR_CENTER));
    push_request(make_req(OP_REPORT, 2'd2, 1'b1, 1000, DIR_CENTER));
    push_request(make_req(OP_START, 2'd2, 1'b0, 0, DIR_CENTER));
    repeat (257) push_request(make_req(OP_TICK, 2'd2, 1'($urandom), $urandom, 8'($urandom)));
    push_request(make_req(OP_STEER, 2'd2, 1'b0, 0, DIR_CENTER));
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
